@@ sv/r2k_pkg.sv @@
// ----------------------------------------------------------------------------
// r2k_pkg
// Shared types, constants and romaji lookup functions for the converter.
// ----------------------------------------------------------------------------
package r2k_pkg;

    localparam int WindowLen = 3;
    localparam int MaxOut    = 8;

    localparam logic OP_CHAR  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] cp_t;

    // one decoded request: up to eight output bytes
    typedef struct packed {
        byte_t [MaxOut-1:0] bytes;
        logic  [3:0]        count;
    } run_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] keep;
        cp_t        k0;
        cp_t        k1;
    } look_t;

    function automatic int vowel_idx(input byte_t c);
        case (c)
            8'h61: vowel_idx = 0;
            8'h69: vowel_idx = 1;
            8'h75: vowel_idx = 2;
            8'h65: vowel_idx = 3;
            8'h6F: vowel_idx = 4;
            default: vowel_idx = -1;
        endcase
    endfunction

    function automatic cp_t vowel_kana(input int v);
        case (v)
            0: vowel_kana = 16'h3042;
            1: vowel_kana = 16'h3044;
            2: vowel_kana = 16'h3046;
            3: vowel_kana = 16'h3048;
            default: vowel_kana = 16'h304A;
        endcase
    endfunction

    function automatic cp_t small_kana(input int v);
        case (v)
            0: small_kana = 16'h3083;
            1: small_kana = 16'h3043;
            2: small_kana = 16'h3085;
            3: small_kana = 16'h3047;
            default: small_kana = 16'h3087;
        endcase
    endfunction

    function automatic look_t look1(input byte_t c);
        look_t r;
        int    v;
        r = '0;
        v = vowel_idx(c);
        r.hit = 1'b1;
        if (v >= 0) r.k0 = vowel_kana(v);
        else if (c >= 8'h30 && c <= 8'h39) r.k0 = 16'hFF10 + {8'h00, c - 8'h30};
        else begin
            case (c)
                8'h2C: r.k0 = 16'h3001;
                8'h2E: r.k0 = 16'h3002;
                8'h2D: r.k0 = 16'h30FC;
                8'h21: r.k0 = 16'hFF01;
                8'h26: r.k0 = 16'hFF06;
                8'h28: r.k0 = 16'hFF08;
                8'h29: r.k0 = 16'hFF09;
                default: r.hit = 1'b0;
            endcase
        end
        return r;
    endfunction

    function automatic logic is_doubled(input byte_t c);
        case (c)
            "b", "c", "d", "f", "g", "h", "j", "k", "m", "p", "r", "s", "t", "v",
            "w", "x", "y", "z": is_doubled = 1'b1;
            default: is_doubled = 1'b0;
        endcase
    endfunction

    // codes of the consonant row, one per vowel, picked by the vowel index below
    function automatic look_t look2(input byte_t a, input byte_t b);
        look_t r;
        int    v;
        cp_t   row [5];
        logic  ok;
        r  = '0;
        v  = vowel_idx(b);
        ok = 1'b1;
        row = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
        case (a)
            "k": row = '{16'h304B, 16'h304D, 16'h304F, 16'h3051, 16'h3053};
            "s": row = '{16'h3055, 16'h3057, 16'h3059, 16'h305B, 16'h305D};
            "t": row = '{16'h305F, 16'h3061, 16'h3064, 16'h3066, 16'h3068};
            "n": row = '{16'h306A, 16'h306B, 16'h306C, 16'h306D, 16'h306E};
            "h": row = '{16'h306F, 16'h3072, 16'h3075, 16'h3078, 16'h307B};
            "m": row = '{16'h307E, 16'h307F, 16'h3080, 16'h3081, 16'h3082};
            "y": row = '{16'h3084, 16'h3044, 16'h3086, 16'h3044, 16'h3088};
            "r": row = '{16'h3089, 16'h308A, 16'h308B, 16'h308C, 16'h308D};
            "w": row = '{16'h308F, 16'h3046, 16'h3046, 16'h3046, 16'h3092};
            "l", "x": row = '{16'h3041, 16'h3043, 16'h3045, 16'h3047, 16'h3049};
            "g": row = '{16'h304C, 16'h304E, 16'h3050, 16'h3052, 16'h3054};
            "z": row = '{16'h3056, 16'h3058, 16'h305A, 16'h305C, 16'h305E};
            "d": row = '{16'h3060, 16'h3062, 16'h3065, 16'h3067, 16'h3069};
            "b": row = '{16'h3070, 16'h3073, 16'h3076, 16'h3079, 16'h307C};
            "p": row = '{16'h3071, 16'h3074, 16'h3077, 16'h307A, 16'h307D};
            "j": row = '{16'h3058, 16'h3058, 16'h3058, 16'h3058, 16'h3058};
            "f": row = '{16'h3075, 16'h3075, 16'h3075, 16'h3075, 16'h3075};
            default: ok = 1'b0;
        endcase
        if (a == "n" && b == "n") begin
            r.hit = 1'b1;
            r.k0  = 16'h3093;
        end else if (a == b && is_doubled(a)) begin
            r.hit  = 1'b1;
            r.keep = 2'd1;
            r.k0   = 16'h3063;
        end else if (ok && v >= 0) begin
            r.hit = 1'b1;
            r.k0  = row[v];
            if (a == "y" && v == 3) r.k1 = 16'h3047;
            if (a == "w" && (v == 1 || v == 3)) r.k1 = small_kana(v);
            if (a == "j" && v != 1) r.k1 = small_kana(v);
            if (a == "f" && v != 2)
                r.k1 = (v == 0) ? 16'h3041 : ((v == 4) ? 16'h3049 : small_kana(v));
        end
        return r;
    endfunction

    function automatic look_t look3(input byte_t a, input byte_t b, input byte_t c);
        look_t r;
        int    v;
        logic  sp;
        cp_t   base;
        logic  ok;
        r  = '0;
        v  = vowel_idx(c);
        sp = (a == "l" || a == "x");
        ok = 1'b1;
        base = '0;
        case (a)
            "k": base = 16'h304D;
            "s": base = 16'h3057;
            "t": base = 16'h3061;
            "n": base = 16'h306B;
            "h": base = 16'h3072;
            "m": base = 16'h307F;
            "r": base = 16'h308A;
            "g": base = 16'h304E;
            "j", "z": base = 16'h3058;
            "d": base = 16'h3062;
            "b": base = 16'h3073;
            default: ok = 1'b0;
        endcase
        if (b == "y" && v >= 0 && sp) begin
            r.hit = 1'b1;
            r.k0  = small_kana(v);
        end else if (b == "y" && v >= 0 && ok) begin
            r.hit = 1'b1;
            r.k0  = base;
            r.k1  = small_kana(v);
        end else if (sp && b == "t" && c == "u") begin
            r.hit = 1'b1;
            r.k0  = 16'h3063;
        end
        return r;
    endfunction

endpackage

@@ sv/r2k_convert.sv @@
// ----------------------------------------------------------------------------
// r2k_convert
// Pending store and single-pass window lookup; builds one output run.
// ----------------------------------------------------------------------------
module r2k_convert (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_op,
    input  r2k_pkg::byte_t in_char,
    output r2k_pkg::run_t  run
);
    import r2k_pkg::*;

    byte_t [1:0] pend_reg, pend_next;
    logic  [1:0] cnt_reg, cnt_next;
    byte_t [2:0] win;
    logic  [1:0] len_m1;
    look_t       l1, l2, l3, hit;
    logic  [1:0] pre;
    run_t        r;

    always_comb
    begin
        win    = '0;
        len_m1 = cnt_reg;
        case (cnt_reg)
            2'd0: win[0] = in_char;
            2'd1: begin win[0] = pend_reg[0]; win[1] = in_char; end
            default: begin win[0] = pend_reg[0]; win[1] = pend_reg[1]; win[2] = in_char;
                len_m1 = 2'd2; end
        endcase
        l1 = look1(in_char);
        l2 = look2(len_m1 == 2'd1 ? win[0] : win[1], in_char);
        l3 = look3(win[0], win[1], in_char);
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        r   = '0;
        hit = '0;
        pre = '0;
        if (len_m1 == 2'd2 && l3.hit) begin hit = l3; pre = 2'd0; end
        else if (len_m1 != 2'd0 && l2.hit) begin hit = l2; pre = len_m1 - 2'd1; end
        else if (l1.hit) begin hit = l1; pre = len_m1; end
        if (in_op == OP_FLUSH) begin
            r.bytes[0] = pend_reg[0];
            r.bytes[1] = pend_reg[1];
            r.count    = {2'b00, len_m1};
            cnt_next   = 2'd0;
        end else if (hit.hit) begin
            r.bytes[0] = win[0];
            r.bytes[1] = win[1];
            r.bytes[pre]      = 8'hE0 | {4'h0, hit.k0[15:12]};
            r.bytes[pre + 1]  = 8'h80 | {2'b00, hit.k0[11:6]};
            r.bytes[pre + 2]  = 8'h80 | {2'b00, hit.k0[5:0]};
            r.bytes[pre + 3]  = 8'hE0 | {4'h0, hit.k1[15:12]};
            r.bytes[pre + 4]  = 8'h80 | {2'b00, hit.k1[11:6]};
            r.bytes[pre + 5]  = 8'h80 | {2'b00, hit.k1[5:0]};
            r.count = {2'b00, pre} + ((hit.k1 != '0) ? 4'd6 : 4'd3);
            pend_next[0] = in_char;
            cnt_next     = hit.keep;
        end else if (len_m1 == 2'd2) begin
            r.bytes[0] = win[0];
            r.count    = 4'd1;
            pend_next  = {win[2], win[1]};
            cnt_next   = 2'd2;
        end else begin
            pend_next = {win[1], win[0]};
            cnt_next  = len_m1 + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (in_valid)
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign run = r;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("pending count out of range");
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_op == OP_FLUSH |=> cnt_reg == 2'd0)
        else $error("flush left bytes pending");
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n) run.count <= 4'd8)
        else $error("run too long");
`endif

endmodule

@@ sv/r2k_serializer.sv @@
// ----------------------------------------------------------------------------
// r2k_serializer
// Holds one run and plays it out a byte per cycle while out_ready is high; takes
// the next run as the last byte leaves, or while empty.
// ----------------------------------------------------------------------------
module r2k_serializer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  r2k_pkg::run_t run,
    output logic          can_load,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_last
);
    import r2k_pkg::*;

    byte_t [MaxOut-1:0] buf_reg;
    logic  [3:0]        cnt_reg;
    logic  [2:0]        idx_reg;
    logic               fin;

    assign out_valid = cnt_reg != 4'd0;
    assign out_last  = cnt_reg == 4'd1;
    assign out_byte  = buf_reg[idx_reg];
    assign fin       = out_valid && out_ready && out_last;
    assign can_load  = !out_valid || fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load && can_load)
        begin
            cnt_reg <= run.count;
            idx_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            cnt_reg <= cnt_reg - 4'd1;
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
            buf_reg <= run.bytes;
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(idx_reg))
        else $error("stalled output moved");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 4'd8)
        else $error("count overflow");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load && out_valid |-> fin)
        else $error("run loaded over a live run");
`endif

endmodule

@@ sv/romaji_to_kana_stream.sv @@
// ----------------------------------------------------------------------------
// romaji_to_kana_stream
// Converts typed romaji bytes to UTF-8 kana on a byte stream.
// ----------------------------------------------------------------------------
// input channel s_axis: one request per typed byte or flush, tuser selects
// flush (1) or byte (0), tdata carries the byte
// output channel m_axis: text bytes, tlast on the final byte of a request
// a request that yields no bytes (held pending) produces nothing
// each request is decoded in one pass in the cycle it is taken; its bytes
// leave from the output buffer one per cycle while m_axis_tready is high, first byte the next cycle
// a request yields 0 to 8 bytes
// the next request is taken while the last byte of the previous run leaves, or while the buffer is empty
// when m_axis_tready is low with a byte waiting, that byte holds and s_axis_tready drops
// reset clears the pending bytes and empties the output buffer
// ----------------------------------------------------------------------------
module romaji_to_kana_stream (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // char_byte
    input  logic       s_axis_tuser,   // operation
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic       m_axis_tlast    // last_of_run
);
    import r2k_pkg::*;

    run_t run;
    logic can_load;
    logic take;

    assign s_axis_tready = can_load;
    assign take          = s_axis_tvalid && can_load;

    r2k_convert u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (take),
        .in_op    (s_axis_tuser),
        .in_char  (s_axis_tdata),
        .run      (run)
    );

    r2k_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .run       (run),
        .can_load  (can_load),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

@@ sim/tb_romaji_to_kana_stream.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_romaji_to_kana_stream
// Feeds typed bytes and flush requests into the converter, predicts the
// UTF-8 text it must produce and compares every output byte and tlast.
// ----------------------------------------------------------------------------
module tb_romaji_to_kana_stream;
    import r2k_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    romaji_to_kana_stream uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    typedef struct packed {
        logic  op;
        byte_t ch;
    } key_req_t;

    typedef struct packed {
        byte_t b;
        logic  last;
    } text_byte_t;

    key_req_t   key_queue[$];
    text_byte_t text_expected[$];

    byte_t held_chars[2];
    int    held_count;

    int  mismatches;
    int  bytes_seen;
    int  keys_sent;
    int  flushes_sent;
    int  drive_gap;
    int  sink_gap;
    int  sink_hold;
    bit  quiet_phase;
    bit  pause_drive;
    bit  stimulus_done;
    bit  in_fire;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------ predictor
    function automatic int vow(byte_t c);
        case (c)
            "a": return 0;
            "i": return 1;
            "u": return 2;
            "e": return 3;
            "o": return 4;
            default: return -1;
        endcase
    endfunction

    function automatic cp_t small_of(int v);
        cp_t t[5] = '{16'h3083, 16'h3043, 16'h3085, 16'h3047, 16'h3087};
        return t[v];
    endfunction

    // returns keep count or -1, kana in k0/k1
    function automatic int romaji_hit(byte_t s[3], int off, int len,
                                      output cp_t k0, output cp_t k1);
        cp_t   vk[5] = '{16'h3042, 16'h3044, 16'h3046, 16'h3048, 16'h304A};
        string cv = "kstnhmyrwlxgzdbpjf";
        string cyv = "kstnhmrgjzdb";
        string dbl = "bcdfghjkmprstvwxyz";
        cp_t   cyb[12] = '{16'h304D, 16'h3057, 16'h3061, 16'h306B, 16'h3072, 16'h307F,
                           16'h308A, 16'h304E, 16'h3058, 16'h3058, 16'h3062, 16'h3073};
        cp_t   rowbase[18] = '{16'h304B, 16'h3055, 16'h305F, 16'h306A, 16'h306F,
                               16'h307E, 16'h3084, 16'h3089, 16'h308F, 16'h3041,
                               16'h3041, 16'h304C, 16'h3056, 16'h3060, 16'h3070,
                               16'h3071, 16'h3058, 16'h3075};
        byte_t a, b, c;
        int    v, ci;
        bit    sp;
        k0 = '0;
        k1 = '0;
        a = s[off];
        b = (len > 1) ? s[off+1] : 8'h00;
        c = (len > 2) ? s[off+2] : 8'h00;
        if (len == 1) begin
            v = vow(a);
            if (v >= 0) begin k0 = vk[v]; return 0; end
            if (a >= "0" && a <= "9") begin k0 = 16'hFF10 + (a - "0"); return 0; end
            case (a)
                ",": k0 = 16'h3001;
                ".": k0 = 16'h3002;
                "-": k0 = 16'h30FC;
                "!": k0 = 16'hFF01;
                "&": k0 = 16'hFF06;
                "(": k0 = 16'hFF08;
                ")": k0 = 16'hFF09;
                default: return -1;
            endcase
            return 0;
        end
        if (len == 2) begin
            if (a == "n" && b == "n") begin k0 = 16'h3093; return 0; end
            if (a == b) for (int i = 0; i < dbl.len(); i++)
                if (dbl[i] == a) begin k0 = 16'h3063; return 1; end
            v = vow(b);
            ci = -1;
            for (int i = 0; i < cv.len(); i++) if (cv[i] == a && ci < 0) ci = i;
            if (ci < 0 || v < 0) return -1;
            case (a)
                "y": begin
                    cp_t yr[5] = '{16'h3084, 16'h3044, 16'h3086, 16'h3044, 16'h3088};
                    k0 = yr[v];
                    if (v == 3) k1 = 16'h3047;
                end
                "w": begin
                    cp_t wr[5] = '{16'h308F, 16'h3046, 16'h3046, 16'h3046, 16'h3092};
                    k0 = wr[v];
                    if (v == 1 || v == 3) k1 = small_of(v);
                end
                "j": begin k0 = 16'h3058; if (v != 1) k1 = small_of(v); end
                "f": begin
                    k0 = 16'h3075;
                    if (v == 0) k1 = 16'h3041;
                    else if (v == 4) k1 = 16'h3049;
                    else if (v != 2) k1 = small_of(v);
                end
                "t": begin
                    cp_t tr[5] = '{16'h305F, 16'h3061, 16'h3064, 16'h3066, 16'h3068};
                    k0 = tr[v];
                end
                "d": begin
                    cp_t dr[5] = '{16'h3060, 16'h3062, 16'h3065, 16'h3067, 16'h3069};
                    k0 = dr[v];
                end
                "n": k0 = 16'h306A + v;
                "h": k0 = 16'h306F + 3 * v;
                "m": begin
                    cp_t mr[5] = '{16'h307E, 16'h307F, 16'h3080, 16'h3081, 16'h3082};
                    k0 = mr[v];
                end
                "r": k0 = 16'h3089 + v;
                "l", "x": k0 = 16'h3041 + 2 * v;
                "b", "p": k0 = rowbase[ci] + 3 * v;
                default: k0 = rowbase[ci] + 2 * v;
            endcase
            return 0;
        end
        v = vow(c);
        sp = (a == "l" || a == "x");
        if (b == "y" && v >= 0) begin
            if (sp) begin k0 = small_of(v); return 0; end
            for (int i = 0; i < cyv.len(); i++)
                if (cyv[i] == a) begin k0 = cyb[i]; k1 = small_of(v); return 0; end
        end
        if (sp && b == "t" && c == "u") begin k0 = 16'h3063; return 0; end
        return -1;
    endfunction

    function automatic void push_kana(ref byte_t run[$], input cp_t cp);
        run.push_back(8'hE0 | cp[15:12]);
        run.push_back(8'h80 | cp[11:6]);
        run.push_back(8'h80 | cp[5:0]);
    endfunction

    task automatic predict_text(key_req_t r);
        byte_t run[$];
        byte_t w[3];
        int    len, keep, sl;
        cp_t   k0, k1;
        if (r.op == OP_FLUSH) begin
            for (int j = 0; j < held_count; j++) run.push_back(held_chars[j]);
            held_count = 0;
        end else begin
            for (int j = 0; j < held_count; j++) w[j] = held_chars[j];
            w[held_count] = r.ch;
            len = held_count + 1;
            keep = -1;
            for (sl = len; sl > 0; sl--) begin
                keep = romaji_hit(w, len - sl, sl, k0, k1);
                if (keep >= 0) break;
            end
            if (keep >= 0) begin
                for (int j = 0; j < len - sl; j++) run.push_back(w[j]);
                push_kana(run, k0);
                if (k1 != 0) push_kana(run, k1);
                for (int j = 0; j < keep; j++) held_chars[j] = w[len - keep + j];
                held_count = keep;
            end else if (len == 3) begin
                run.push_back(w[0]);
                held_chars[0] = w[1];
                held_chars[1] = w[2];
                held_count = 2;
            end else begin
                for (int j = 0; j < len; j++) held_chars[j] = w[j];
                held_count = len;
            end
        end
        foreach (run[j]) text_expected.push_back('{b: run[j], last: (j == run.size() - 1)});
    endtask

    // ------------------------------------------------------------ driver
    always @(posedge clk) begin
        in_fire <= rst_n && s_axis_tvalid && s_axis_tready;
    end

    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= OP_CHAR;
            drive_gap     <= 0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (drive_gap > 0) begin
                drive_gap     <= drive_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (key_queue.size() > 0 && !pause_drive) begin
                key_req_t r;
                r = key_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= r.op;
                s_axis_tdata  <= r.ch;
                if (!quiet_phase && $urandom_range(0, 5) == 0)
                    drive_gap <= $urandom_range(1, 5);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
        end else if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold     <= sink_hold - 1;
        end else if (sink_gap > 0) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= sink_gap - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 5) == 0) sink_gap <= $urandom_range(1, 5);
        end
    end

    // ------------------------------------------------------------ monitor
    always @(posedge clk) begin
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_text('{op: s_axis_tuser, ch: s_axis_tdata});
            if (s_axis_tuser == OP_FLUSH) flushes_sent++;
            else keys_sent++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            bytes_seen++;
            if (text_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected byte %h last %b", m_axis_tdata, m_axis_tlast);
            end else begin
                text_byte_t e;
                e = text_expected.pop_front();
                if (e.b !== m_axis_tdata || e.last !== m_axis_tlast) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("byte mismatch: expected %h/%b got %h/%b",
                                 e.b, e.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------ stimulus
    task automatic add_key(byte_t c);
        key_queue.push_back('{op: OP_CHAR, ch: c});
    endtask

    task automatic add_flush(byte_t c);
        key_queue.push_back('{op: OP_FLUSH, ch: c});
    endtask

    task automatic add_word(string s);
        for (int i = 0; i < s.len(); i++) add_key(s[i]);
    endtask

    task automatic wait_drained();
        while (key_queue.size() > 0 || s_axis_tvalid || text_expected.size() > 0)
            @(posedge clk);
    endtask

    function automatic byte_t pick_romaji();
        string pool = "kstnhmyrwlxgzdbpjfaiueoaiueoaiueonnyyc";
        string odd = "0123456789,.-!&()KAQ~ vqc";
        int    r;
        r = $urandom_range(0, 19);
        if (r < 16) return pool[$urandom_range(0, pool.len() - 1)];
        if (r < 19) return odd[$urandom_range(0, odd.len() - 1)];
        return byte_t'($urandom_range(0, 255));
    endfunction

    initial begin
        string words[] = '{"kya", "ka", "nn", "ye", "bba", "ltu", "xyo", "shi", "wi",
                           "ja", "fa", "fu", "kk", "ryu", "lyu", "sha", "gya"};
        int    n;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_CHAR;
        m_axis_tready = 1'b0;
        held_count = 0;
        held_chars = '{8'h00, 8'h00};
        mismatches = 0;
        bytes_seen = 0;
        keys_sent = 0;
        flushes_sent = 0;
        sink_hold = 0;
        quiet_phase = 1'b0;
        pause_drive = 1'b0;
        stimulus_done = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: table entries, extremes, flush on empty, upper case, non-ASCII
        add_flush(8'hFF);
        add_word("kya");
        add_word("nn");
        add_word("ye");
        add_word("bba");
        add_key(8'h00);
        add_key(8'hFF);
        add_key("K");
        add_key("A");
        add_flush(8'h00);
        add_word("kk");
        add_flush(8'hAA);
        add_word("9(");
        add_key(8'h80);
        add_key(8'h7F);
        add_flush(8'h55);
        wait_drained();

        // input stalls behind a full output buffer while the sink is held off
        pause_drive = 1'b1;
        for (int i = 0; i < 12; i++) add_word("kya");
        sink_hold = 60;
        pause_drive = 1'b0;
        wait_drained();

        // random: mostly syllables, some noise and broken sequences
        n = 0;
        while (n < 250) begin
            if ($urandom_range(0, 9) < 6) begin
                string w;
                w = words[$urandom_range(0, words.size() - 1)];
                add_word(w);
                n += w.len();
            end else begin
                add_key(pick_romaji());
                n++;
            end
            if ($urandom_range(0, 14) == 0) begin
                add_flush(byte_t'($urandom_range(0, 255)));
                n++;
            end
            if (n > 200) quiet_phase = 1'b1;
            while (key_queue.size() > 8) @(posedge clk);
        end
        add_flush(8'h00);
        wait_drained();
        stimulus_done = 1'b1;
        repeat (20) @(posedge clk);

        $display("sent %0d typed bytes and %0d flushes, checked %0d output bytes",
                 keys_sent, flushes_sent, bytes_seen);
        if (mismatches == 0 && text_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d bytes outstanding", mismatches,
                     text_expected.size());
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
sv/r2k_pkg.sv
sv/r2k_convert.sv
sv/r2k_serializer.sv
sv/romaji_to_kana_stream.sv
sim/tb_romaji_to_kana_stream.sv
